FILE: src/sha256_byte_stream_hasher_defines.svh
// Assertion macros for the byte stream hasher.
`ifndef SHA256_BYTE_STREAM_HASHER_DEFINES_SVH
`define SHA256_BYTE_STREAM_HASHER_DEFINES_SVH
`ifndef SYNTH
`define SHA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define SHA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SHA_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define SHA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: src/sha256_pkg.sv
// ----------------------------------------------------------------------------
// sha256_pkg
// Shared types, round constants and helper functions for the SHA-256 hasher.
// ----------------------------------------------------------------------------
package sha256_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_message;
    } in_item_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } out_item_t;

    // byte source for the block buffer write
    typedef enum logic [1:0] {
        SRC_DATA = 2'd0,
        SRC_PAD  = 2'd1,
        SRC_ZERO = 2'd2,
        SRC_LEN  = 2'd3
    } byte_src_t;

    typedef struct packed {
        logic      buf_write;
        byte_src_t buf_src;
        logic      count_bits;  // add 512 to length after a full block
        logic      load;        // start compression: load a..h from the chain
        logic      round;       // one round step
        logic      fold;        // chain += a..h
        logic      restart;     // back to initial hash values
        logic      shift_out;   // rotate chain toward output
    } dp_cmd_t;

    typedef struct packed {
        logic [5:0] fill;
        logic [5:0] rnd;
    } dp_status_t;

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
        32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
        32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
        32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
        32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
        32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
        32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
        32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
        32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
        32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
        32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2
    };

    localparam logic [31:0] INIT_HASH [8] = '{
        32'h6a09e667,32'hbb67ae85,32'h3c6ef372,32'ha54ff53a,
        32'h510e527f,32'h9b05688c,32'h1f83d9ab,32'h5be0cd19
    };

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_START = 6'd56;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage

FILE: src/sha256_datapath.sv
// ----------------------------------------------------------------------------
// sha256_datapath
// Block bytes, length counter, schedule window, round registers and chain.
// ----------------------------------------------------------------------------
module sha256_datapath (
    input  logic                   clk,
    input  logic                   rst_n,
    input  sha256_pkg::dp_cmd_t    cmd,
    input  logic [7:0]             data_byte,
    output sha256_pkg::dp_status_t status,
    output logic [31:0]            head_word
);

    logic [5:0]  fill_reg, fill_next;
    logic [63:0] bits_reg, bits_next;
    logic [31:0] chain_reg [8];
    logic [31:0] w_reg [16];
    logic [31:0] v_reg [8];
    logic [5:0]  rnd_reg, rnd_next;
    logic [7:0]  wr_byte;
    logic [63:0] total;
    logic [2:0]  len_sel;
    logic [31:0] w_cur, w_new, t1, t2, s0, s1, e, a;

    assign total   = bits_reg + {55'd0, fill_reg, 3'd0};
    assign len_sel = 3'd7 - fill_reg[2:0];

    always_comb
    begin
        unique case (cmd.buf_src)
            sha256_pkg::SRC_DATA: wr_byte = data_byte;
            sha256_pkg::SRC_PAD:  wr_byte = sha256_pkg::PAD_BYTE;
            sha256_pkg::SRC_ZERO: wr_byte = 8'd0;
            sha256_pkg::SRC_LEN:  wr_byte = bits_reg[{len_sel, 3'd0} +: 8];
            default:              wr_byte = 8'd0;
        endcase
    end

    // the 0x80 write freezes the message length in bits_reg; fill keeps
    // moving through the padding, so the length bytes read bits_reg only
    always_comb
    begin
        fill_next = fill_reg;
        bits_next = bits_reg;
        if (cmd.restart)
        begin
            fill_next = '0;
            bits_next = '0;
        end
        else if (cmd.buf_write)
        begin
            fill_next = fill_reg + 6'd1;
        end
        if (cmd.count_bits)
            bits_next = bits_reg + 64'd512;
        if (cmd.buf_write && cmd.buf_src == sha256_pkg::SRC_PAD)
            bits_next = total;
    end

    // schedule: w_reg[0] is the current word, window shifts each round
    assign s0 = sha256_pkg::rotr(w_reg[1], 7) ^ sha256_pkg::rotr(w_reg[1], 18)
              ^ (w_reg[1] >> 3);
    assign s1 = sha256_pkg::rotr(w_reg[14], 17) ^ sha256_pkg::rotr(w_reg[14], 19)
              ^ (w_reg[14] >> 10);
    assign w_new = s1 + w_reg[9] + s0 + w_reg[0];
    assign w_cur = w_reg[0];
    assign e = v_reg[4];
    assign a = v_reg[0];
    assign t1 = v_reg[7] + (sha256_pkg::rotr(e, 6) ^ sha256_pkg::rotr(e, 11)
              ^ sha256_pkg::rotr(e, 25)) + ((e & v_reg[5]) ^ (~e & v_reg[6]))
              + sha256_pkg::ROUND_K[rnd_reg] + w_cur;
    assign t2 = (sha256_pkg::rotr(a, 2) ^ sha256_pkg::rotr(a, 13) ^ sha256_pkg::rotr(a, 22))
              + ((a & v_reg[1]) ^ (a & v_reg[2]) ^ (v_reg[1] & v_reg[2]));

    always_comb
    begin
        rnd_next = rnd_reg;
        if (cmd.load)
            rnd_next = '0;
        else if (cmd.round)
            rnd_next = rnd_reg + 6'd1;
    end

    // block bytes are packed big-endian straight into the schedule window;
    // no byte arrives while rounds run, and every block is fully rewritten
    always_ff @(posedge clk)
    begin
        if (cmd.buf_write)
            w_reg[fill_reg[5:2]][{~fill_reg[1:0], 3'd0} +: 8] <= wr_byte;
        else if (cmd.load)
        begin
            for (int i = 0; i < 8; i++)
                v_reg[i] <= chain_reg[i];
        end
        else if (cmd.round)
        begin
            for (int i = 0; i < 15; i++)
                w_reg[i] <= w_reg[i+1];
            w_reg[15] <= w_new;
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            bits_reg <= '0;
            rnd_reg  <= '0;
            for (int i = 0; i < 8; i++)
                chain_reg[i] <= sha256_pkg::INIT_HASH[i];
        end
        else
        begin
            fill_reg <= fill_next;
            bits_reg <= bits_next;
            rnd_reg  <= rnd_next;
            if (cmd.restart)
            begin
                for (int i = 0; i < 8; i++)
                    chain_reg[i] <= sha256_pkg::INIT_HASH[i];
            end
            else if (cmd.fold)
            begin
                for (int i = 0; i < 8; i++)
                    chain_reg[i] <= chain_reg[i] + v_reg[i];
            end
            else if (cmd.shift_out)
            begin
                for (int i = 0; i < 7; i++)
                    chain_reg[i] <= chain_reg[i+1];
                chain_reg[7] <= chain_reg[0];
            end
        end
    end

    assign status.fill = fill_reg;
    assign status.rnd  = rnd_reg;
    assign head_word   = chain_reg[0];

endmodule

FILE: src/sha256_control.sv
// ----------------------------------------------------------------------------
// sha256_control
// Sequencer: byte intake, padding, compression rounds and digest output.
// ----------------------------------------------------------------------------
module sha256_control (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  sha256_pkg::in_item_t   in_item,
    output logic                   in_stall,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [2:0]             out_index,
    input  sha256_pkg::dp_status_t status,
    output sha256_pkg::dp_cmd_t    cmd
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_LOAD  = 6'b000010,
        ST_ROUND = 6'b000100,
        ST_FOLD  = 6'b001000,
        ST_PAD   = 6'b010000,
        ST_OUT   = 6'b100000
    } state_t;

    state_t     state_reg, state_next;
    logic       fin_reg, fin_next;     // finishing the message
    logic       len_reg, len_next;     // 0x80 already written
    logic       ovf_reg, ovf_next;     // 0x80 landed past byte 55: no length here
    logic [2:0] idx_reg, idx_next;
    logic       accept;

    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_valid = (state_reg == ST_OUT);
    assign out_index = idx_reg;

    always_comb
    begin
        state_next = state_reg;
        fin_next   = fin_reg;
        len_next   = len_reg;
        ovf_next   = ovf_reg;
        idx_next   = idx_reg;
        cmd        = '0;
        cmd.buf_src = sha256_pkg::SRC_DATA;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    fin_next = in_item.end_of_message;
                    len_next = 1'b0;
                    ovf_next = 1'b0;
                    if (in_item.byte_present)
                    begin
                        cmd.buf_write = 1'b1;
                        if (status.fill == 6'd63)
                        begin
                            cmd.count_bits = 1'b1;
                            state_next = ST_LOAD;
                        end
                        else if (in_item.end_of_message)
                            state_next = ST_PAD;
                    end
                    else if (in_item.end_of_message)
                        state_next = ST_PAD;
                end
            end
            ST_PAD:
            begin
                // first pad cycle writes 0x80, then zeros, then the length
                cmd.buf_write = 1'b1;
                if (!len_reg)
                begin
                    cmd.buf_src = sha256_pkg::SRC_PAD;
                    len_next = 1'b1;
                    ovf_next = (status.fill >= sha256_pkg::LEN_START);
                end
                else if (!ovf_reg && status.fill >= sha256_pkg::LEN_START)
                    cmd.buf_src = sha256_pkg::SRC_LEN;
                else
                    cmd.buf_src = sha256_pkg::SRC_ZERO;
                if (status.fill == 6'd63)
                begin
                    // a block that carries the length ends the message,
                    // otherwise one more block of zeros and length follows
                    if (len_reg && !ovf_reg)
                        fin_next = 1'b0;
                    ovf_next = 1'b0;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                cmd.load = 1'b1;
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                cmd.round = 1'b1;
                if (status.rnd == 6'd63)
                    state_next = ST_FOLD;
            end
            ST_FOLD:
            begin
                cmd.fold = 1'b1;
                if (len_reg && !fin_reg)
                begin
                    idx_next = '0;
                    state_next = ST_OUT;
                end
                else if (fin_reg)
                    state_next = ST_PAD;
                else
                    state_next = ST_IDLE;
            end
            ST_OUT:
            begin
                if (!out_stall)
                begin
                    cmd.shift_out = 1'b1;
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == 3'd7)
                    begin
                        cmd.shift_out = 1'b0;
                        cmd.restart = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fin_reg   <= 1'b0;
            len_reg   <= 1'b0;
            ovf_reg   <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            fin_reg   <= fin_next;
            len_reg   <= len_next;
            ovf_reg   <= ovf_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

FILE: src/sha256_byte_stream_hasher.sv
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher
// SHA-256 over a byte stream; emits the digest as eight 32-bit words.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_stall carries in_item: one byte per request, with
// byte_present and end_of_message flags. Output channel out_valid/out_stall
// carries out_item: digest word, its index 0..7 and a last-word flag.
// A byte that does not fill the block leaves the input open for the next byte.
// A byte that fills the block stalls the input through one load, 64 rounds
// (one per cycle on the shared round unit) and one fold into the chain value.
// An end request pads one byte per cycle up to 64 bytes, compresses and,
// when 0x80 lands past byte 55, pads and compresses a second
// block. Then eight words are offered, one per cycle while not stalled;
// a stalled word holds. After word 7 the chain returns to the initial values.
// Reset restores the initial hash values and clears fill count and length;
// no item is held.
module sha256_byte_stream_hasher (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  sha256_pkg::in_item_t    in_item,
    output logic                    out_valid,
    input  logic                    out_stall,
    output sha256_pkg::out_item_t   out_item
);

`include "sha256_byte_stream_hasher_defines.svh"

    sha256_pkg::dp_cmd_t    cmd;
    sha256_pkg::dp_status_t status;
    logic [31:0]            head_word;
    logic [2:0]             out_index;

    sha256_control u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_item   (in_item),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_index (out_index),
        .status    (status),
        .cmd       (cmd)
    );

    sha256_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .data_byte (in_item.data_byte),
        .status    (status),
        .head_word (head_word)
    );

    assign out_item.digest_word = head_word;
    assign out_item.word_index  = out_index;
    assign out_item.last_word   = (out_index == 3'd7);

    `SHA_ASSERT_IMPL(a_no_in_during_out, clk, rst_n, out_valid, in_stall)
    `SHA_ASSERT_NEXT(a_restart_fill, clk, rst_n, cmd.restart, status.fill == 6'd0)
    `SHA_ASSERT_IMPL(a_one_op, clk, rst_n, cmd.round, !cmd.load && !cmd.buf_write)

endmodule
